FILE: sv/imuda_pkg.sv
package imuda_pkg;

    localparam int SLOTS    = 4;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CHANNELS = 7;
    localparam int AXES     = 6;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [8:0] DECIM_RESET = 9'd8;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_POP    = 1'b1
    } t_op;

    typedef struct packed {
        logic               action;
        logic signed [19:0] acc_x;
        logic signed [19:0] acc_y;
        logic signed [19:0] acc_z;
        logic signed [19:0] gyro_x;
        logic signed [19:0] gyro_y;
        logic signed [19:0] gyro_z;
        logic signed [15:0] temp_raw;
        logic               link_err;
        logic        [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic               slot_valid;
        logic signed [31:0] acc_x_total;
        logic signed [31:0] acc_y_total;
        logic signed [31:0] acc_z_total;
        logic signed [31:0] gyro_x_total;
        logic signed [31:0] gyro_y_total;
        logic signed [31:0] gyro_z_total;
        logic signed [31:0] temp_total;
        logic        [31:0] slot_time;
        logic               error_seen;
    } t_out_item;

    // Command passed from the front end to the back end through the queue.
    typedef struct packed {
        t_op                    op;
        logic [AXES-1:0][19:0]  axis;
        logic [15:0]            temp;
        logic                   link_err;
        logic [31:0]            now_ms;
    } t_cmd;

    typedef logic [CHANNELS-1:0][31:0] t_sums;

    typedef struct packed {
        t_sums       sums;
        logic [31:0] stamp;
    } t_slot_row;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(SLOTS - 1)) begin
            r = '0;
        end else begin
            r = s + 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: sv/imuda_front.sv
module imuda_front
    import imuda_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready,
    output t_cmd     o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    // Decode the item kind; a frame error on a pop carries no meaning.
    always_comb begin
        n_cmd.op       = i_item.action ? OP_POP : OP_SAMPLE;
        n_cmd.axis[0]  = i_item.acc_x;
        n_cmd.axis[1]  = i_item.acc_y;
        n_cmd.axis[2]  = i_item.acc_z;
        n_cmd.axis[3]  = i_item.gyro_x;
        n_cmd.axis[4]  = i_item.gyro_y;
        n_cmd.axis[5]  = i_item.gyro_z;
        n_cmd.temp     = i_item.temp_raw;
        n_cmd.link_err = i_item.link_err & ~i_item.action;
        n_cmd.now_ms   = i_item.now_ms;
    end

    assign o_ready     = ~r_valid | i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: sv/imuda_queue.sv
module imuda_queue
    import imuda_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    t_cmd              r_entry [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_entry[r_rd_ptr];
    assign push         = i_push_valid & o_push_ready;
    assign pop          = o_pop_valid & i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

FILE: sv/imuda_back.sv
module imuda_back
    import imuda_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_data,
    input  logic       i_cmd_valid,
    output logic       o_cmd_ready,
    input  t_cmd       i_cmd,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_item  o_result
);

    // Ring of completed slots; the slot being filled lives in r_acc.
    t_slot_row         r_ring [SLOTS];
    t_slot_row         r_rd_row;

    logic [8:0]        r_decim;
    t_sums             r_acc;
    logic [SLOT_W-1:0] r_wr_slot;
    logic [SLOT_W-1:0] r_rd_slot;
    logic [8:0]        r_count;
    logic              r_err;
    logic              r_out_valid;
    logic              r_out_slot_valid;
    logic              r_out_err;

    t_sums             n_acc;
    logic [SLOT_W-1:0] n_wr_slot;
    logic [SLOT_W-1:0] n_rd_slot;
    logic [8:0]        n_count;
    logic              n_err;
    logic              n_out_slot_valid;
    logic              n_out_err;

    t_sums             sum;
    logic [8:0]        count_inc;
    logic [SLOT_W-1:0] wr_next;
    logic              exec;
    logic              ring_we;
    logic              ring_re;

    assign o_cmd_ready = ~r_out_valid | i_ready;
    assign exec        = i_cmd_valid & o_cmd_ready;
    assign count_inc   = r_count + 1'b1;
    assign wr_next     = next_slot(r_wr_slot);

    always_comb begin
        for (int c = 0; c < AXES; c++) begin
            sum[c] = r_acc[c] + {{12{i_cmd.axis[c][19]}}, i_cmd.axis[c]};
        end
        sum[CHANNELS-1] = r_acc[CHANNELS-1] + {{16{i_cmd.temp[15]}}, i_cmd.temp};
    end

    always_comb begin
        n_acc            = r_acc;
        n_wr_slot        = r_wr_slot;
        n_rd_slot        = r_rd_slot;
        n_count          = r_count;
        n_err            = r_err;
        n_out_slot_valid = 1'b0;
        n_out_err        = r_err;
        ring_we          = 1'b0;
        ring_re          = 1'b0;
        case (i_cmd.op)
            OP_SAMPLE: begin
                n_acc     = sum;
                n_count   = count_inc;
                n_err     = r_err | i_cmd.link_err;
                n_out_err = n_err;
                if (count_inc >= r_decim) begin
                    n_count = '0;
                    if (wr_next != r_rd_slot) begin
                        ring_we   = 1'b1;
                        n_acc     = '0;
                        n_wr_slot = wr_next;
                    end
                end
            end
            OP_POP: begin
                n_err = 1'b0;
                if (r_wr_slot != r_rd_slot) begin
                    ring_re          = 1'b1;
                    n_out_slot_valid = 1'b1;
                    n_rd_slot        = next_slot(r_rd_slot);
                end
            end
            default: begin
                n_out_err = r_err;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decim          <= DECIM_RESET;
            r_acc            <= '0;
            r_wr_slot        <= '0;
            r_rd_slot        <= '0;
            r_count          <= '0;
            r_err            <= 1'b0;
            r_out_valid      <= 1'b0;
            r_out_slot_valid <= 1'b0;
            r_out_err        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_decim <= i_cfg_data;
            end
            if (exec) begin
                r_acc            <= n_acc;
                r_wr_slot        <= n_wr_slot;
                r_rd_slot        <= n_rd_slot;
                r_count          <= n_count;
                r_err            <= n_err;
                r_out_valid      <= 1'b1;
                r_out_slot_valid <= n_out_slot_valid;
                r_out_err        <= n_out_err;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec && ring_we) begin
            r_ring[r_wr_slot] <= '{sums: sum, stamp: i_cmd.now_ms};
        end
        if (exec && ring_re) begin
            r_rd_row <= r_ring[r_rd_slot];
        end
    end

    always_comb begin
        o_result.slot_valid   = r_out_slot_valid;
        o_result.acc_x_total  = r_out_slot_valid ? r_rd_row.sums[0] : '0;
        o_result.acc_y_total  = r_out_slot_valid ? r_rd_row.sums[1] : '0;
        o_result.acc_z_total  = r_out_slot_valid ? r_rd_row.sums[2] : '0;
        o_result.gyro_x_total = r_out_slot_valid ? r_rd_row.sums[3] : '0;
        o_result.gyro_y_total = r_out_slot_valid ? r_rd_row.sums[4] : '0;
        o_result.gyro_z_total = r_out_slot_valid ? r_rd_row.sums[5] : '0;
        o_result.temp_total   = r_out_slot_valid ? r_rd_row.sums[6] : '0;
        o_result.slot_time    = r_out_slot_valid ? r_rd_row.stamp : '0;
        o_result.error_seen   = r_out_err;
    end

    assign o_valid = r_out_valid;

endmodule

FILE: sv/imu_decimating_accumulator_fifo.sv
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_item   (t_in_item)
// result    out        o_valid / i_ready    o_result (t_out_item)
// config    in         i_cfg_we             i_cfg_data (decimation ratio, 9 bits)
//
// One item is taken per cycle while o_ready is high, and each gives exactly one result,
// offered once it has passed the front register, the queue and the result register.
// The back end executes one command per cycle while its result is taken; a pop reads
// the ring through a registered read port, so items can follow each other with no gap.
// Reset is synchronous and active low and needs no clearing pass of the ring.
// A stalled result holds the back end; input is taken until four items are in flight.
module imu_decimating_accumulator_fifo
    import imuda_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_item   i_item,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_item  o_result
);

    logic front_valid;
    logic front_ready;
    t_cmd front_cmd;
    logic back_valid;
    logic back_ready;
    t_cmd back_cmd;

    // The front end decodes each transfer into a sample or pop command and
    // registers it, so the input handshake never sees the result side.
    imuda_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    // A short command queue lets the two halves stall independently.
    imuda_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_cmd   (front_cmd),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_cmd    (back_cmd)
    );

    // The back end owns all slot state, the sticky error flag and the
    // decimation ratio, and drives the result register.
    imuda_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (back_valid),
        .o_cmd_ready (back_ready),
        .i_cmd       (back_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result)
    );

endmodule
